FILE: hdl/skyra_pkg.sv
// ----------------------------------------------------------------------------
// skyra_pkg
// Shared widths and field constants for the skyline range-assign unit.
// ----------------------------------------------------------------------------
package skyra_pkg;

  localparam int unsigned LEFT_W      = 10;
  localparam int unsigned RIGHT_W     = 11;
  localparam int unsigned BLOCK_W     = 16;
  localparam int unsigned HEIGHT_W    = 32;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 64;

  typedef logic [HEIGHT_W-1:0] height_t;

endpackage

FILE: hdl/skyra_colmem.sv
// ----------------------------------------------------------------------------
// skyra_colmem
// Single-port column height memory with registered read data.
// ----------------------------------------------------------------------------
module skyra_colmem #(
  parameter int unsigned COLUMNS = 1024
) (
  input  logic                       clk_i,
  input  logic [$clog2(COLUMNS)-1:0] addr_i,
  input  logic                       we_i,
  input  skyra_pkg::height_t         wdata_i,
  output skyra_pkg::height_t         rdata_o
);
  import skyra_pkg::*;

  height_t mem_q [COLUMNS];
  height_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/skyline_range_assign_max_tree_unit.sv
// ----------------------------------------------------------------------------
// skyline_range_assign_max_tree_unit
// Falling-block skyline: range maximum, saturating add, range assign.
// ----------------------------------------------------------------------------
// Column heights live in one single-port memory of COLUMNS words. After reset
// a clearing pass zeroes every word of the memory; no beat is taken then.
// A drop over a span of columns makes one memory read per cycle through the
// shared max unit, then one write per cycle; an empty span skips both. Since
// every assign is at least the span maximum, the row maximum is tracked in a
// register. One beat is in work at a time; the output register frees the
// result from the next input beat.
module skyline_range_assign_max_tree_unit #(
  parameter int unsigned COLUMNS = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // left_edge[9:0], right_edge[20:10], block_height[36:21], zero pad
  input  logic [skyra_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // landed_top[31:0], overall_max[63:32]
  output logic [skyra_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // empty_span[0]
  output logic                                  m_axis_tuser
);
  import skyra_pkg::*;

  localparam int unsigned AW = $clog2(COLUMNS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [AW:0]        idx_q, idx_d, left_q, left_d, right_q, right_d;
  logic [BLOCK_W-1:0] blk_q, blk_d;
  height_t            acc_q, acc_d, top_q, top_d, gmax_q, gmax_d;
  logic               empty_q, empty_d, pend_q, pend_d;
  height_t            out_top_q, out_top_d, out_max_q, out_max_d;
  logic               out_empty_q, out_empty_d, out_vld_q, out_vld_d;

  logic [LEFT_W-1:0]  in_left;
  logic [RIGHT_W-1:0] in_right;
  logic [AW:0]        right_c;
  logic               in_empty;
  height_t            rdata, fold, wdata;
  logic [HEIGHT_W:0]  sum;
  logic               we;

  assign in_left  = s_axis_tdata[LEFT_W-1:0];
  assign in_right = s_axis_tdata[LEFT_W+RIGHT_W-1:LEFT_W];
  assign right_c  = (32'(in_right) > 32'(COLUMNS)) ? (AW+1)'(COLUMNS)
                                                     : (AW+1)'(in_right);
  assign in_empty = 32'(in_left) >= 32'(right_c);

  // shared compare / add unit
  assign fold = (pend_q && rdata > acc_q) ? rdata : acc_q;
  assign sum  = {1'b0, fold} + (HEIGHT_W+1)'(blk_q);

  assign we    = (state_q == S_CLEAR) || (state_q == S_WRITE);
  assign wdata = (state_q == S_CLEAR) ? '0 : top_q;

  skyra_colmem #(.COLUMNS(COLUMNS)) u_mem (
    .clk_i  (clk_i),
    .addr_i (idx_q[AW-1:0]),
    .we_i   (we),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    left_d      = left_q;
    right_d     = right_q;
    blk_d       = blk_q;
    acc_d       = fold;
    top_d       = top_q;
    gmax_d      = gmax_q;
    empty_d     = empty_q;
    pend_d      = 1'b0;
    out_top_d   = out_top_q;
    out_max_d   = out_max_q;
    out_empty_d = out_empty_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    unique case (state_q)
      S_CLEAR: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == (AW+1)'(COLUMNS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          left_d  = (AW+1)'(in_left);
          idx_d   = (AW+1)'(in_left);
          right_d = right_c;
          blk_d   = s_axis_tdata[LEFT_W+RIGHT_W+BLOCK_W-1:LEFT_W+RIGHT_W];
          acc_d   = '0;
          empty_d = in_empty;
          top_d   = '0;
          state_d = in_empty ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        pend_d = 1'b1;
        idx_d  = idx_q + 1'b1;
        if (idx_q == right_q - 1'b1) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        top_d   = sum[HEIGHT_W] ? '1 : sum[HEIGHT_W-1:0];
        idx_d   = left_q;
        state_d = S_WRITE;
      end
      S_WRITE: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == right_q - 1'b1) begin
          gmax_d  = (top_q > gmax_q) ? top_q : gmax_q;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_top_d   = top_q;
          out_max_d   = gmax_q;
          out_empty_d = empty_q;
          out_vld_d   = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      idx_q     <= '0;
      pend_q    <= 1'b0;
      gmax_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      pend_q    <= pend_d;
      gmax_q    <= gmax_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q      <= left_d;
    right_q     <= right_d;
    blk_q       <= blk_d;
    acc_q       <= acc_d;
    top_q       <= top_d;
    empty_q     <= empty_d;
    out_top_q   <= out_top_d;
    out_max_q   <= out_max_d;
    out_empty_q <= out_empty_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_max_q, out_top_q};
  assign m_axis_tuser  = out_empty_q;

endmodule

FILE: hdl/skyra_checker.sv
// ----------------------------------------------------------------------------
// skyra_checker
// Port-level checks for the skyline range-assign unit.
// ----------------------------------------------------------------------------
module skyra_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [skyra_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic                              m_axis_tuser
);
  import skyra_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[HEIGHT_W-1:0] == '0)
    else $error("empty span with nonzero top");

  a_max_ge_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:HEIGHT_W] >= m_axis_tdata[HEIGHT_W-1:0])
    else $error("row max below landed top");

  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

endmodule

bind skyline_range_assign_max_tree_unit skyra_checker u_skyra_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tuser (m_axis_tuser)
);

FILE: bench/tb_skyline_range_assign_max_tree_unit.sv
// ----------------------------------------------------------------------------
// tb_skyline_range_assign_max_tree_unit
// Self-checking bench for the falling-block skyline unit.
// ----------------------------------------------------------------------------
// Drops are sent as stream beats in random bursts. A column-array model in
// the scoreboard predicts the new block top, the row maximum and the empty
// flag of each drop. Results are checked in order while the receiver stalls
// on its own pattern and once holds off for a long stretch. A final phase
// sends a few drops back to back.
`timescale 1ns / 1ps

class skyline_scoreboard;
  localparam int unsigned NCOL = 1024;

  bit [31:0] col_height [NCOL];
  bit [31:0] row_max;
  bit [64:0] pending_q [$];
  int unsigned mismatches;

  function new();
    foreach (col_height[i]) col_height[i] = '0;
    row_max = '0;
    mismatches = 0;
  endfunction

  function void note_drop(bit [9:0] left_e, bit [10:0] right_e, bit [15:0] blk_h);
    int unsigned r;
    bit [31:0] span_top;
    bit [32:0] sum;
    bit [31:0] top;
    bit empty;
    r = (right_e > NCOL) ? NCOL : right_e;
    top = '0;
    empty = 1'b0;
    if (left_e >= r) begin
      empty = 1'b1;
    end else begin
      span_top = '0;
      for (int unsigned i = left_e; i < r; i++)
        if (col_height[i] > span_top) span_top = col_height[i];
      sum = {1'b0, span_top} + 33'(blk_h);
      top = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      for (int unsigned i = left_e; i < r; i++) col_height[i] = top;
      if (top > row_max) row_max = top;
    end
    pending_q.push_back({empty, row_max, top});
  endfunction

  function void check_result(bit [63:0] data, bit user);
    bit [64:0] want;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected beat: top=%h max=%h empty=%b", data[31:0], data[63:32], user);
      return;
    end
    want = pending_q.pop_front();
    if (want[31:0] !== data[31:0] || want[63:32] !== data[63:32] || want[64] !== user) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: top exp=%h act=%h  max exp=%h act=%h  empty exp=%b act=%b",
                 want[31:0], data[31:0], want[63:32], data[63:32], want[64], user);
    end
  endfunction
endclass

module tb_skyline_range_assign_max_tree_unit;
  import skyra_pkg::*;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  skyline_scoreboard sb;
  int unsigned burst_left;
  bit          no_gaps;
  bit          hold_req;

  skyline_range_assign_max_tree_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_drop(bit [9:0] left_e, bit [10:0] right_e, bit [15:0] blk_h);
    int unsigned gap;
    if (burst_left == 0 && !no_gaps) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, blk_h, right_e, left_e};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_drop(left_e, right_e, blk_h);
  endtask

  // receiver: random ready mode redrawn when the phase counter wraps, one long hold-off on request
  initial begin
    int unsigned hold_cnt;
    int unsigned mode;
    int unsigned phase;
    hold_cnt = 0;
    mode = 0;
    phase = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (hold_req && hold_cnt == 0) begin
        hold_req = 1'b0;
        hold_cnt = 600;
      end
      if (++phase == 150) begin
        phase = 0;
        mode = $urandom_range(0, 3);
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 0);
          2: m_axis_tready <= ($urandom_range(0, 7) != 0);
          default: m_axis_tready <= (phase % 5 < 2);
        endcase
      end
    end
  end

  initial begin
    bit [9:0]  l;
    bit [10:0] r;
    bit [15:0] h;
    int unsigned sel;
    sb = new();
    burst_left = 0;
    no_gaps = 1'b0;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    send_drop(10'd0, 11'd1024, 16'hFFFF);
    send_drop(10'd5, 11'd5, 16'h1234);
    send_drop(10'd20, 11'd3, 16'h0001);
    send_drop(10'd1023, 11'd2047, 16'h0000);
    send_drop(10'd1023, 11'd1024, 16'h8000);
    send_drop(10'd0, 11'd0, 16'hFFFF);
    send_drop(10'd0, 11'd1, 16'h0001);
    send_drop(10'd1, 11'd2, 16'h0000);
    send_drop(10'd0, 11'd2, 16'h00FF);
    send_drop(10'd1023, 11'd1023, 16'h0005);
    send_drop(10'd500, 11'd1500, 16'h7FFF);
    send_drop(10'd511, 11'd513, 16'h0100);
    send_drop(10'd0, 11'd1024, 16'h0000);
    send_drop(10'd300, 11'd200, 16'hAAAA);
    send_drop(10'd512, 11'd1024, 16'h5555);
    send_drop(10'd0, 11'd512, 16'h0001);
    send_drop(10'd100, 11'd101, 16'hFFFF);
    send_drop(10'd99, 11'd103, 16'h0002);

    // random
    for (int i = 0; i < 950; i++) begin
      if (i == 300) hold_req = 1'b1;
      l = 10'($urandom_range(0, 1023));
      h = 16'($urandom_range(0, 65535));
      sel = $urandom_range(0, 99);
      if (sel < 4) r = 11'($urandom_range(0, 2047));
      else if (sel < 9) r = 11'($urandom_range(0, 32'(l)));
      else r = 11'(32'(l) + $urandom_range(1, 16));
      send_drop(l, r, h);
    end

    // a few drops back to back
    no_gaps = 1'b1;
    send_drop(10'd700, 11'd701, 16'hFFFF);
    send_drop(10'd699, 11'd702, 16'hFFFF);
    send_drop(10'd0, 11'd1024, 16'h0001);
    send_drop(10'd3, 11'd3, 16'h0000);
    s_axis_tvalid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

FILE: files.f
hdl/skyra_pkg.sv
hdl/skyra_colmem.sv
hdl/skyline_range_assign_max_tree_unit.sv
hdl/skyra_checker.sv
bench/tb_skyline_range_assign_max_tree_unit.sv
